@@ sv/btlv_pkg.sv @@
// Shared types, constants and the control program of the BER TLV header encoder.
package btlv_pkg;

    localparam int LENGTH_BYTES = 4;
    localparam logic [31:0] LEN_LIMIT = (LENGTH_BYTES >= 4) ? 32'hFFFF_FFFF :
        32'((64'd1 << (8 * LENGTH_BYTES)) - 64'd1);

    localparam logic [7:0] TAG_ESC   = 8'h1F;
    localparam logic [7:0] LONG_FORM = 8'h80;
    localparam logic [31:0] SHORT_MAX = 32'd127;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_IDLE  = 4'd0;
    localparam t_pc PC_CHK   = 4'd1;
    localparam t_pc PC_ID    = 4'd2;
    localparam t_pc PC_T2    = 4'd3;
    localparam t_pc PC_TAG1  = 4'd4;
    localparam t_pc PC_TAG0  = 4'd5;
    localparam t_pc PC_LSEL  = 4'd6;
    localparam t_pc PC_LHDR  = 4'd7;
    localparam t_pc PC_LBYTE = 4'd8;
    localparam t_pc PC_SHORT = 4'd9;
    localparam t_pc PC_ERR   = 4'd10;

    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_ID,
        SRC_TAG1,
        SRC_TAG0,
        SRC_LHDR,
        SRC_LBYTE,
        SRC_SHORT,
        SRC_ERR
    } t_src;

    typedef enum logic [2:0] {
        C_NEVER,
        C_BAD,
        C_TLEN1,
        C_TLEN2,
        C_SHORT,
        C_LMORE
    } t_cond;

    typedef enum logic [1:0] {
        L_NONE,
        L_ZERO,
        L_ONE
    } t_lastm;

    typedef struct packed {
        t_src   src;
        t_cond  cond;
        t_pc    target;
        t_lastm lastm;
        logic   fin;
    } t_uword;

    typedef struct packed {
        logic bad;
        logic tlen1;
        logic tlen2;
        logic short_len;
        logic lmore;
    } t_flags;

    function automatic t_uword ucode(input t_pc pc);
        t_uword uw;
        uw = '{src: SRC_NONE, cond: C_NEVER, target: PC_IDLE, lastm: L_NONE, fin: 1'b0};
        case (pc)
            PC_CHK: begin
                uw.cond = C_BAD;
                uw.target = PC_ERR;
            end
            PC_ID: begin
                uw.src = SRC_ID;
                uw.cond = C_TLEN1;
                uw.target = PC_LSEL;
            end
            PC_T2: begin
                uw.cond = C_TLEN2;
                uw.target = PC_TAG0;
            end
            PC_TAG1: uw.src = SRC_TAG1;
            PC_TAG0: uw.src = SRC_TAG0;
            PC_LSEL: begin
                uw.cond = C_SHORT;
                uw.target = PC_SHORT;
            end
            PC_LHDR: uw.src = SRC_LHDR;
            PC_LBYTE: begin
                uw.src = SRC_LBYTE;
                uw.cond = C_LMORE;
                uw.target = PC_LBYTE;
                uw.fin = 1'b1;
            end
            PC_SHORT: begin
                uw.src = SRC_SHORT;
                uw.lastm = L_ZERO;
                uw.fin = 1'b1;
            end
            PC_ERR: begin
                uw.src = SRC_ERR;
                uw.lastm = L_ONE;
                uw.fin = 1'b1;
            end
            default: uw.fin = 1'b0;
        endcase
        return uw;
    endfunction

endpackage

@@ sv/btlv_useq.sv @@
// Step counter and control store that sequence the header octets.
module btlv_useq
    import btlv_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_out_free,
    input  t_flags i_flags,
    output t_uword o_uword,
    output logic   o_idle,
    output logic   o_load
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword uw;
    logic   emit;
    logic   step_ok;
    logic   taken;

    assign uw      = ucode(r_pc);
    assign emit    = (uw.src != SRC_NONE);
    assign step_ok = !emit || i_out_free;

    always_comb begin
        case (uw.cond)
            C_BAD:   taken = i_flags.bad;
            C_TLEN1: taken = i_flags.tlen1;
            C_TLEN2: taken = i_flags.tlen2;
            C_SHORT: taken = i_flags.short_len;
            C_LMORE: taken = i_flags.lmore;
            default: taken = 1'b0;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        if (r_pc == PC_IDLE) begin
            if (i_start) begin
                n_pc = PC_CHK;
            end
        end else if (step_ok) begin
            if (taken) begin
                n_pc = uw.target;
            end else if (uw.fin) begin
                n_pc = PC_IDLE;
            end else begin
                n_pc = r_pc + t_pc'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = uw;
    assign o_idle  = (r_pc == PC_IDLE);
    assign o_load  = (r_pc != PC_IDLE) && emit && i_out_free;

endmodule

@@ sv/ber_tlv_header_encoder.sv @@
// Top level of the BER TLV header encoder: header registers, content pass-through, output stage.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_stall   kind, tag, class, constructed, length, data byte
//   output   out        o_valid / i_stall   out_byte, last, error
//
// A content byte is registered in the output stage and passes at one byte per cycle while the output does not stall.
// A header passes through its accepting cycle, a check step, the skip steps PC_T2 and PC_LSEL
// where the program visits them, and one step per emitted octet, set by the microcode step
// counter that emits one octet a step and holds a step while the output stalls.
// Reset clears the step counter, the output valid and the pending content count.
// A stalled output holds its octet, and the input stalls until the header program finishes.
module ber_tlv_header_encoder
    import btlv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [23:0] i_tag_bytes,
    input  logic [1:0]  i_tag_class,
    input  logic        i_constructed,
    input  logic [31:0] i_content_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic        o_error
);

    logic        seq_idle;
    logic        seq_load;
    t_uword      uw;
    t_flags      flags;
    logic        out_free;
    logic        acc;
    logic        hdr_acc;
    logic        dat_load;

    logic [7:0]  oct0;
    logic [7:0]  oct1;
    logic [7:0]  oct2;
    logic        tl3;
    logic        tl2;
    logic [7:0]  top_oct;
    logic        hdr_bad;
    logic [31:0] len_sat;
    logic [2:0]  len_cnt;
    logic [31:0] len_al;

    logic [31:0] r_rem;
    logic        r_bad;
    logic        r_tl1;
    logic        r_tl2;
    logic [7:0]  r_id;
    logic [7:0]  r_oct1;
    logic [7:0]  r_oct0;
    logic [31:0] r_len;
    logic        r_short;
    logic [2:0]  r_lcnt;
    logic [31:0] r_lsh;

    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_olast;
    logic        r_oerr;
    logic [7:0]  n_obyte;
    logic        n_olast;

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = !(seq_idle && out_free);
    assign acc      = i_valid && !o_stall;
    assign hdr_acc  = acc && !i_kind;
    assign dat_load = acc && i_kind && (r_rem != 32'd0);

    assign oct0    = i_tag_bytes[7:0];
    assign oct1    = i_tag_bytes[15:8];
    assign oct2    = i_tag_bytes[23:16];
    assign tl3     = (oct2 != 8'd0);
    assign tl2     = !tl3 && (oct1 != 8'd0);
    assign top_oct = tl3 ? oct2 : (tl2 ? oct1 : oct0);
    assign hdr_bad = (tl3 || tl2) &&
        (((top_oct & TAG_ESC) != TAG_ESC) || (tl3 && !oct1[7]) || oct0[7]);
    assign len_sat = (i_content_length > LEN_LIMIT) ? LEN_LIMIT : i_content_length;

    always_comb begin
        if (len_sat[31:24] != 8'd0) begin
            len_cnt = 3'd4;
            len_al  = len_sat;
        end else if (len_sat[23:16] != 8'd0) begin
            len_cnt = 3'd3;
            len_al  = {len_sat[23:0], 8'd0};
        end else if (len_sat[15:8] != 8'd0) begin
            len_cnt = 3'd2;
            len_al  = {len_sat[15:0], 16'd0};
        end else begin
            len_cnt = 3'd1;
            len_al  = {len_sat[7:0], 24'd0};
        end
    end

    assign flags.bad       = r_bad;
    assign flags.tlen1     = r_tl1;
    assign flags.tlen2     = r_tl2;
    assign flags.short_len = r_short;
    assign flags.lmore     = (r_lcnt != 3'd1);

    btlv_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (hdr_acc),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_uword    (uw),
        .o_idle     (seq_idle),
        .o_load     (seq_load)
    );

    always_comb begin
        case (uw.src)
            SRC_ID:    n_obyte = r_id;
            SRC_TAG1:  n_obyte = r_oct1;
            SRC_TAG0:  n_obyte = r_oct0;
            SRC_LHDR:  n_obyte = LONG_FORM | {5'd0, r_lcnt};
            SRC_LBYTE: n_obyte = r_lsh[31:24];
            SRC_SHORT: n_obyte = r_len[7:0];
            default:   n_obyte = 8'd0;
        endcase
        case (uw.lastm)
            L_ZERO:  n_olast = (r_len == 32'd0);
            L_ONE:   n_olast = 1'b1;
            default: n_olast = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hdr_acc) begin
            r_bad   <= hdr_bad;
            r_tl1   <= !tl3 && !tl2;
            r_tl2   <= tl2;
            r_id    <= {i_tag_class, i_constructed, top_oct[4:0]};
            r_oct1  <= oct1;
            r_oct0  <= oct0;
            r_len   <= len_sat;
            r_short <= (len_sat <= SHORT_MAX);
            r_lcnt  <= len_cnt;
            r_lsh   <= len_al;
        end else if (seq_load && (uw.src == SRC_LBYTE)) begin
            r_lcnt <= r_lcnt - 3'd1;
            r_lsh  <= {r_lsh[23:0], 8'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 32'd0;
        end else if (hdr_acc) begin
            r_rem <= hdr_bad ? 32'd0 : len_sat;
        end else if (dat_load) begin
            r_rem <= r_rem - 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (seq_load || dat_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dat_load) begin
            r_obyte <= i_data_byte;
            r_olast <= (r_rem == 32'd1);
            r_oerr  <= 1'b0;
        end else if (seq_load) begin
            r_obyte <= n_obyte;
            r_olast <= n_olast;
            r_oerr  <= (uw.src == SRC_ERR);
        end
    end

    assign o_valid    = r_ovalid;
    assign o_out_byte = r_obyte;
    assign o_last     = r_olast;
    assign o_error    = r_oerr;

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_last && (o_out_byte == 8'd0)))
        else $error("An error request must be a zero final octet.");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !seq_idle |-> o_stall)
        else $error("Input accepted while the header program runs.");

    a_hdr_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hdr_acc |=> !seq_idle)
        else $error("Header request did not start the program.");

    a_rem_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dat_load |=> (r_rem == $past(r_rem) - 32'd1))
        else $error("Pending content count did not step down.");

    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(seq_load && dat_load))
        else $error("Two sources loaded the output register at once.");

endmodule

@@ tb/ber_tlv_header_encoder_test.sv @@
// Self-checking testbench for the BER TLV header encoder with a predicting octet scoreboard.

typedef struct packed {
    logic [7:0] octet;
    logic       is_last;
    logic       err;
} t_enc_octet;

class btlv_scoreboard;
    logic [31:0] content_left;
    t_enc_octet  expected_octets[$];
    int          mismatches;

    function new();
        content_left = '0;
        mismatches = 0;
    endfunction

    function void push_octet(logic [7:0] octet, logic is_last, logic err);
        expected_octets.push_back('{octet: octet, is_last: is_last, err: err});
    endfunction

    function int pending();
        return expected_octets.size();
    endfunction

    // Returns the number of octets that the accepted request produces.
    function int note_request(logic kind, logic [23:0] tag, logic [1:0] cls, logic cons,
                              logic [31:0] len, logic [7:0] data);
        logic [7:0]  oct [3];
        logic [31:0] n;
        logic        bad;
        int          tlen;
        int          cnt;
        int          i;
        int          before_cnt;
        before_cnt = expected_octets.size();
        if (kind) begin
            if (content_left == 0) return 0;
            content_left = content_left - 1;
            push_octet(data, content_left == 0, 1'b0);
            return 1;
        end
        oct[0] = tag[7:0];
        oct[1] = tag[15:8];
        oct[2] = tag[23:16];
        tlen = (oct[2] != 0) ? 3 : ((oct[1] != 0) ? 2 : 1);
        bad = 1'b0;
        if (tlen > 1) begin
            if (oct[tlen-1][4:0] != 5'h1F) bad = 1'b1;
            for (i = 1; i < tlen - 1; i++) begin
                if (!oct[i][7]) bad = 1'b1;
            end
            if (oct[0][7]) bad = 1'b1;
            if (bad) begin
                content_left = '0;
                push_octet(8'h00, 1'b1, 1'b1);
                return 1;
            end
        end
        n = (len > btlv_pkg::LEN_LIMIT) ? btlv_pkg::LEN_LIMIT : len;
        push_octet({cls, cons, oct[tlen-1][4:0]}, 1'b0, 1'b0);
        for (i = tlen - 2; i >= 0; i--) begin
            push_octet(oct[i], 1'b0, 1'b0);
        end
        if (n > btlv_pkg::SHORT_MAX) begin
            cnt = 1;
            while (cnt < 4 && (n >> (8 * cnt)) != 0) cnt++;
            push_octet(btlv_pkg::LONG_FORM | 8'(cnt), 1'b0, 1'b0);
            for (i = cnt - 1; i >= 0; i--) begin
                push_octet(n[8*i +: 8], 1'b0, 1'b0);
            end
        end else begin
            push_octet({1'b0, n[6:0]}, n == 0, 1'b0);
        end
        content_left = n;
        return expected_octets.size() - before_cnt;
    endfunction

    function void check_result(logic [7:0] octet, logic is_last, logic err);
        t_enc_octet want;
        if (expected_octets.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected octet %02h last %0b error %0b", octet, is_last, err);
            return;
        end
        want = expected_octets.pop_front();
        if (want.octet !== octet || want.is_last !== is_last || want.err !== err) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"octet mismatch: expected %02h last %0b error %0b, ",
                          "got %02h last %0b error %0b"},
                         want.octet, want.is_last, want.err, octet, is_last, err);
        end
    endfunction
endclass

module ber_tlv_header_encoder_test
    import btlv_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 80;
    localparam int HOLD_CYCLES    = 200;
    localparam int END_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = 1'b0;
    logic [23:0] i_tag_bytes = '0;
    logic [1:0]  i_tag_class = '0;
    logic        i_constructed = 1'b0;
    logic [31:0] i_content_length = '0;
    logic [7:0]  i_data_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        o_error;

    btlv_scoreboard sb;
    logic hold_req = 1'b0;
    int   burst_left = 0;
    int   effective_items = 0;
    int   idle_cycles = 0;

    ber_tlv_header_encoder i_dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic send_item(input logic kind, input logic [23:0] tag, input logic [1:0] cls,
                             input logic cons, input logic [31:0] len, input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 16);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_kind <= kind;
        i_tag_bytes <= tag;
        i_tag_class <= cls;
        i_constructed <= cons;
        i_content_length <= len;
        i_data_byte <= data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (sb.note_request(kind, tag, cls, cons, len, data) > 0) effective_items++;
    endtask

    task automatic send_data(input logic [7:0] data);
        send_item(1'b1, 24'($urandom), 2'($urandom), 1'($urandom), $urandom, data);
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic send_random_element();
        logic [23:0] tag;
        logic [31:0] len;
        int          nd;
        int          r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            send_data(8'($urandom));
        end else if (r == 1) begin
            send_item(1'b0, 24'($urandom), 2'($urandom), 1'($urandom), $urandom, 8'($urandom));
            repeat ($urandom_range(0, 2)) send_data(8'($urandom));
        end else begin
            case ($urandom_range(0, 2))
                0: tag = {16'h0000, 8'($urandom)};
                1: tag = {8'h00, 3'($urandom), 5'h1F, 1'b0, 7'($urandom)};
                default: tag = {3'($urandom), 5'h1F, 1'b1, 7'($urandom), 1'b0, 7'($urandom)};
            endcase
            case ($urandom_range(0, 9))
                0: len = $urandom;
                1: len = $urandom >> (8 * $urandom_range(1, 3));
                2: len = $urandom_range(120, 300);
                default: len = $urandom_range(0, 8);
            endcase
            nd = (len <= 16) ? int'(len) : $urandom_range(0, 5);
            case ($urandom_range(0, 7))
                0: nd = nd + 1;
                1: if (nd > 0) nd = nd - 1;
                default: nd = nd;
            endcase
            send_item(1'b0, tag, 2'($urandom), 1'($urandom), len, 8'($urandom));
            repeat (nd) send_data(8'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_out_byte, o_last, o_error);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("[ber_tlv_header_encoder] ERROR");
                $finish;
            end
        end
    end

    initial begin : receiver
        int period;
        int duty;
        int seg_left;
        int phase;
        period = 1;
        duty = 0;
        seg_left = 0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    period = $urandom_range(1, 8);
                    duty = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, period);
                    seg_left = $urandom_range(10, 60);
                    phase = 0;
                end
                seg_left--;
                i_stall <= (phase < duty);
                phase = (phase + 1) % period;
            end
        end
    end

    initial begin : stimulus
        logic held;
        logic drained;
        sb = new();
        held = 1'b0;
        drained = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(1'b0, 24'h000000, 2'd0, 1'b0, 32'd0, 8'h00);
        send_item(1'b0, 24'h0000FF, 2'd3, 1'b1, 32'd3, 8'h00);
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'hA5);
        send_item(1'b0, 24'h001F05, 2'd1, 1'b0, 32'd127, 8'h00);
        send_data(8'h5A);
        send_item(1'b0, 24'h1F8130, 2'd2, 1'b1, 32'hFFFF_FFFF, 8'h00);
        send_data(8'h11);
        send_item(1'b0, 24'h001E05, 2'd0, 1'b0, 32'd4, 8'h00);
        send_data(8'h22);
        send_item(1'b0, 24'h1F0530, 2'd1, 1'b1, 32'd1, 8'h00);
        send_item(1'b0, 24'h001F85, 2'd2, 1'b0, 32'd2, 8'h00);
        send_item(1'b0, 24'hFFFFFF, 2'd3, 1'b1, 32'd5, 8'hFF);
        send_item(1'b0, 24'h3F8101, 2'd0, 1'b0, 32'd128, 8'h00);
        send_item(1'b0, 24'h001F7F, 2'd1, 1'b0, 32'd256, 8'h00);
        send_item(1'b0, 24'h00001E, 2'd2, 1'b1, 32'h0001_0000, 8'h00);
        send_item(1'b0, 24'h001F01, 2'd0, 1'b0, 32'd1, 8'h00);
        send_data(8'h80);
        send_data(8'h33);
        send_item(1'b0, 24'h3FFF7F, 2'd3, 1'b1, 32'd2, 8'h00);
        send_data(8'h01);
        send_data(8'hFE);

        effective_items = 0;
        while (effective_items < RANDOM_ITEMS) begin
            if (effective_items >= 30 && !held) begin
                held = 1'b1;
                hold_req = 1'b1;
            end
            if (effective_items >= 60 && !drained) begin
                drained = 1'b1;
                pause_until_drained();
            end
            send_random_element();
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ber_tlv_header_encoder] OK");
        end else begin
            $display("[ber_tlv_header_encoder] ERROR");
        end
        $finish;
    end

endmodule
